// File: rtl/core/sm4_pkg.sv
`default_nettype none
package sm4_pkg;

  // round count and counter width
  localparam int ROUNDS = 32;
  localparam int RND_W  = $clog2(ROUNDS);

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [1:0] CFG_MODE     = 2'd2;

  // system parameter words
  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  // sequencer states
  typedef enum logic [1:0] {
    ST_KLOAD,
    ST_KEXP,
    ST_IDLE,
    ST_ENC
  } state_t;

  // controls from sequencer to round datapath
  typedef struct packed {
    logic             load_key;
    logic             load_blk;
    logic             step;
    logic             key_mode;
    logic [RND_W-1:0] rnd;
  } ctl_t;

  // round constants for the key schedule
  localparam logic [31:0] CK_TABLE [ROUNDS] = '{
    32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
    32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
    32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
    32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
    32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
    32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
    32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
    32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
  };

  // s-box
  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // byte-wise s-box substitution
  function automatic logic [31:0] tau(input logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // linear transform of the data rounds
  function automatic logic [31:0] lin_data(input logic [31:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // linear transform of the key schedule
  function automatic logic [31:0] lin_key(input logic [31:0] b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sm4_rk_mem.sv
`default_nettype none
module sm4_rk_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [sm4_pkg::RND_W-1:0]  waddr,
  input  wire logic [31:0]                wdata,
  input  wire logic [sm4_pkg::RND_W-1:0]  raddr,
  output logic      [31:0]                rdata
);

  logic [31:0] mem [sm4_pkg::ROUNDS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/sm4_round.sv
`default_nettype none
module sm4_round (
  input  wire logic            clk,
  input  wire sm4_pkg::ctl_t   ctl,
  input  wire logic [63:0]     key_high,
  input  wire logic [63:0]     key_low,
  input  wire logic [63:0]     blk_high,
  input  wire logic [63:0]     blk_low,
  input  wire logic [31:0]     rk,
  output logic      [31:0]     new_word,
  output logic      [63:0]     res_high,
  output logic      [63:0]     res_low
);

  logic [31:0] w_r [4];
  logic [31:0] t;
  logic [31:0] s;
  logic [31:0] lin;

  // shared round function: key schedule or data round
  always_comb begin
    t        = w_r[1] ^ w_r[2] ^ w_r[3] ^ (ctl.key_mode ? sm4_pkg::CK_TABLE[ctl.rnd] : rk);
    s        = sm4_pkg::tau(t);
    lin      = ctl.key_mode ? sm4_pkg::lin_key(s) : sm4_pkg::lin_data(s);
    new_word = w_r[0] ^ lin;
  end

  // word shift register
  always_ff @(posedge clk) begin
    if (ctl.load_key) begin
      w_r[0] <= key_high[63:32] ^ sm4_pkg::FK0;
      w_r[1] <= key_high[31:0]  ^ sm4_pkg::FK1;
      w_r[2] <= key_low[63:32]  ^ sm4_pkg::FK2;
      w_r[3] <= key_low[31:0]   ^ sm4_pkg::FK3;
    end else if (ctl.load_blk) begin
      w_r[0] <= blk_high[63:32];
      w_r[1] <= blk_high[31:0];
      w_r[2] <= blk_low[63:32];
      w_r[3] <= blk_low[31:0];
    end else if (ctl.step) begin
      w_r[0] <= w_r[1];
      w_r[1] <= w_r[2];
      w_r[2] <= w_r[3];
      w_r[3] <= new_word;
    end
  end

  // result words in reversed order
  assign res_high = {w_r[3], w_r[2]};
  assign res_low  = {w_r[1], w_r[0]};

endmodule
`default_nettype wire

// File: rtl/core/sm4_ctrl.sv
`default_nettype none
module sm4_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       rekey,
  input  wire logic                       mode,
  output logic                            busy,
  output logic                            out_valid,
  output sm4_pkg::ctl_t                   ctl,
  output logic                            mem_we,
  output logic      [sm4_pkg::RND_W-1:0]  mem_raddr
);

  localparam logic [sm4_pkg::RND_W-1:0] RND_LAST = sm4_pkg::RND_W'(sm4_pkg::ROUNDS - 1);

  sm4_pkg::state_t           state_r, state_nxt;
  logic [sm4_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [sm4_pkg::RND_W-1:0] rd_rnd;

  // state, round counter and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sm4_pkg::ST_KLOAD;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and controls
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = 1'b0;
    ctl           = '0;
    ctl.rnd       = rnd_r;
    mem_we        = 1'b0;
    rd_rnd        = '0;
    case (state_r)
      sm4_pkg::ST_KLOAD: begin
        ctl.load_key = 1'b1;
        ctl.key_mode = 1'b1;
        rnd_nxt      = '0;
        state_nxt    = sm4_pkg::ST_KEXP;
      end
      sm4_pkg::ST_KEXP: begin
        ctl.step     = 1'b1;
        ctl.key_mode = 1'b1;
        mem_we       = 1'b1;
        rnd_nxt      = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          state_nxt = sm4_pkg::ST_IDLE;
        end
      end
      sm4_pkg::ST_IDLE: begin
        // first round key is fetched while waiting
        rd_rnd = '0;
        if (start) begin
          ctl.load_blk = 1'b1;
          rnd_nxt      = '0;
          state_nxt    = sm4_pkg::ST_ENC;
        end
      end
      sm4_pkg::ST_ENC: begin
        ctl.step = 1'b1;
        rd_rnd   = rnd_r + 1'b1;
        rnd_nxt  = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          out_valid_nxt = 1'b1;
          state_nxt     = sm4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sm4_pkg::ST_KLOAD;
      end
    endcase
    // a key or mode write restarts the schedule
    if (rekey) begin
      state_nxt     = sm4_pkg::ST_KLOAD;
      out_valid_nxt = 1'b0;
    end
  end

  // decryption walks the key store backwards
  assign mem_raddr = mode ? (RND_LAST - rd_rnd) : rd_rnd;
  assign busy      = (state_r != sm4_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: rtl/core/sm4_block_cipher.sv
// SM4 block cipher, 128-bit block, ECB.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 key bits 127..64,
// 1 key bits 63..0, 2 mode: bit 0, 0 encrypt and 1 decrypt); index 3 is ignored.
// Each write to index 0, 1 or 2 starts the key schedule: a key load state, then one
// round key per cycle written to the 32-entry round key memory. busy is high
// meanwhile. After reset the schedule runs once on the all-zero key.
// Input: an item is taken at a clock edge with start high and busy low; the
// block words come on in_block_high / in_block_low at that edge only.
// Processing: 32 rounds, one per cycle, each round key fetched ahead of its
// round through the registered memory read port. The result appears on
// out_high / out_low with out_valid high for one cycle once the last round
// is done. busy drops in that same cycle, so a new item may be started there;
// the single round unit takes no new item before the last one is finished.
// The receiver cannot stall; out_valid is a one-cycle strobe.
// Reset (rst_n low, synchronous) clears the key and mode and aborts any item.
`default_nettype none
module sm4_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  output logic             out_valid,
  output logic      [63:0] out_high,
  output logic      [63:0] out_low,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0]               key_high_r;
  logic [63:0]               key_low_r;
  logic                      mode_r;
  logic                      rekey;
  sm4_pkg::ctl_t             ctl;
  logic                      mem_we;
  logic [sm4_pkg::RND_W-1:0] mem_raddr;
  logic [31:0]               rk;
  logic [31:0]               new_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      mode_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sm4_pkg::CFG_KEY_HIGH: key_high_r <= cfg_data;
        sm4_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_data;
        sm4_pkg::CFG_MODE:     mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // any write within the register list reruns the schedule
  assign rekey = cfg_we && (cfg_index == sm4_pkg::CFG_KEY_HIGH ||
                            cfg_index == sm4_pkg::CFG_KEY_LOW ||
                            cfg_index == sm4_pkg::CFG_MODE);

  sm4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .rekey     (rekey),
    .mode      (mode_r),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl),
    .mem_we    (mem_we),
    .mem_raddr (mem_raddr)
  );

  sm4_rk_mem u_rk_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ctl.rnd),
    .wdata (new_word),
    .raddr (mem_raddr),
    .rdata (rk)
  );

  sm4_round u_round (
    .clk      (clk),
    .ctl      (ctl),
    .key_high (key_high_r),
    .key_low  (key_low_r),
    .blk_high (in_block_high),
    .blk_low  (in_block_low),
    .rk       (rk),
    .new_word (new_word),
    .res_high (out_high),
    .res_low  (out_low)
  );

endmodule
`default_nettype wire

// File: rtl/core/sm4_chk.sv
`default_nettype none
module sm4_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic       cfg_we,
  input wire logic [1:0] cfg_index
);

  // result strobe only shows once the engine is free
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an accepted item occupies the engine
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but engine not busy");

  // a key or mode register write starts the key schedule
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == sm4_pkg::CFG_KEY_HIGH || cfg_index == sm4_pkg::CFG_KEY_LOW ||
                cfg_index == sm4_pkg::CFG_MODE)) |=> busy)
    else $error("register write did not start key schedule");

  // results never come in consecutive cycles
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind sm4_block_cipher sm4_chk u_sm4_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);
`default_nettype wire

// File: tb/sv/sm4_checker.sv
module sm4_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        out_valid,
  input  logic [63:0] out_high,
  input  logic [63:0] out_low,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          blocks_pending
);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  // key schedule system parameter
  localparam logic [31:0] FAMILY_KEY [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  // byte substitution table
  localparam logic [7:0] SUBST [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // mirror of the block's configuration and key store
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic        decrypt;
  logic        keys_ready;
  logic [31:0] round_keys [sm4_pkg::ROUNDS];
  block_t      expected_blocks [$];
  int          err_count;

  initial begin
    err_count      = 0;
    mismatches     = 0;
    blocks_pending = 0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] a);
    return {SUBST[a[31:24]], SUBST[a[23:16]], SUBST[a[15:8]], SUBST[a[7:0]]};
  endfunction

  function automatic logic [31:0] diffuse_data(input logic [31:0] b);
    return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
  endfunction

  function automatic logic [31:0] diffuse_key(input logic [31:0] b);
    return b ^ rotl32(b, 13) ^ rotl32(b, 23);
  endfunction

  // round constant: byte j of round r is 7*(4r+j) mod 256
  function automatic logic [31:0] round_const(input int r);
    logic [31:0] w;
    for (int j = 0; j < 4; j++) begin
      w[31 - 8*j -: 8] = 8'((4*r + j) * 7);
    end
    return w;
  endfunction

  // key schedule from the current key registers
  task automatic expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] t;
    k[0] = key_hi[63:32] ^ FAMILY_KEY[0];
    k[1] = key_hi[31:0]  ^ FAMILY_KEY[1];
    k[2] = key_lo[63:32] ^ FAMILY_KEY[2];
    k[3] = key_lo[31:0]  ^ FAMILY_KEY[3];
    for (int r = 0; r < sm4_pkg::ROUNDS; r++) begin
      t = k[(r+1)%4] ^ k[(r+2)%4] ^ k[(r+3)%4] ^ round_const(r);
      k[r%4] = k[r%4] ^ diffuse_key(subst_word(t));
      round_keys[r] = k[r%4];
    end
    keys_ready = 1'b1;
  endtask

  // 32 data rounds, word-reversed output
  function automatic block_t sm4_crypt(input logic [63:0] hi, input logic [63:0] lo);
    logic [31:0] x [4];
    logic [31:0] rk;
    logic [31:0] t;
    block_t      res;
    x[0] = hi[63:32];
    x[1] = hi[31:0];
    x[2] = lo[63:32];
    x[3] = lo[31:0];
    for (int r = 0; r < sm4_pkg::ROUNDS; r++) begin
      rk = decrypt ? round_keys[sm4_pkg::ROUNDS-1-r] : round_keys[r];
      t = x[(r+1)%4] ^ x[(r+2)%4] ^ x[(r+3)%4] ^ rk;
      x[r%4] = x[r%4] ^ diffuse_data(subst_word(t));
    end
    res.hi = {x[3], x[2]};
    res.lo = {x[1], x[0]};
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (err_count < 60)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  // watch results, register writes and accepted items
  always @(posedge clk) begin : watch
    block_t want;
    if (!rst_n) begin
      key_hi     = '0;
      key_lo     = '0;
      decrypt    = 1'b0;
      keys_ready = 1'b0;
      expected_blocks.delete();
    end else begin
      // result compare against the oldest outstanding item
      if (out_valid) begin
        if (expected_blocks.size() == 0) begin
          report("result with no item outstanding", out_high, out_low);
        end else begin
          want = expected_blocks.pop_front();
          if (out_high !== want.hi) report("out_high", out_high, want.hi);
          if (out_low !== want.lo) report("out_low", out_low, want.lo);
        end
      end
      // register write restarts the key schedule
      if (cfg_we) begin
        case (cfg_index)
          sm4_pkg::CFG_KEY_HIGH: begin
            key_hi = cfg_data;
            expand_round_keys();
          end
          sm4_pkg::CFG_KEY_LOW: begin
            key_lo = cfg_data;
            expand_round_keys();
          end
          sm4_pkg::CFG_MODE: begin
            decrypt = cfg_data[0];
            expand_round_keys();
          end
          default: ;
        endcase
      end
      // accepted item
      if (start && !busy) begin
        if (!keys_ready) expand_round_keys();
        expected_blocks.push_back(sm4_crypt(in_block_high, in_block_low));
      end
    end
    mismatches     <= err_count;
    blocks_pending <= expected_blocks.size();
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

  localparam int ITEM_TARGET  = 650;
  localparam int CALM_TAIL    = 80;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;

  // index past the last register
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam logic [63:0] MODE_ENC = 64'd0;
  localparam logic [63:0] MODE_DEC = 64'd1;

  // standard key / plaintext and its ciphertext
  localparam logic [63:0] STD_KEY_HI = 64'h0123456789abcdef;
  localparam logic [63:0] STD_KEY_LO = 64'hfedcba9876543210;
  localparam logic [63:0] STD_CT_HI  = 64'h681edf34d206965e;
  localparam logic [63:0] STD_CT_LO  = 64'h86b3e94f536e4246;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_block_high;
  logic [63:0] in_block_low;
  logic        out_valid;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  int          mismatches;
  int          blocks_pending;
  int          items_sent;
  int          cycle_count;

  sm4_block_cipher dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_block_high(in_block_high),
    .in_block_low (in_block_low),
    .out_valid    (out_valid),
    .out_high     (out_high),
    .out_low      (out_low),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sm4_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_block_high (in_block_high),
    .in_block_low  (in_block_low),
    .out_valid     (out_valid),
    .out_high      (out_high),
    .out_low       (out_low),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .blocks_pending(blocks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // random 64-bit word, biased toward the extremes
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {$urandom, 32'h0};
      3: return {32'hffffffff, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // present one item and hold it until accepted; returns at a falling edge
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    start         = 1'b1;
    in_block_high = hi;
    in_block_low  = lo;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  // register write once the block is idle with nothing outstanding
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    start = 1'b0;
    do @(posedge clk); while (busy || blocks_pending != 0);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // sender gap of one idle burst
  task automatic sender_gap();
    start = 1'b0;
    repeat ($urandom_range(1, 18)) @(negedge clk);
  endtask

  initial begin : stimulus
    bit gaps_on;
    int phase_len;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_block_high = '0;
    in_block_low  = '0;
    cfg_we        = 1'b0;
    cfg_index     = sm4_pkg::CFG_KEY_HIGH;
    cfg_data      = '0;
    items_sent    = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // items before any key write run on the all-zero key
    send_block('0, '0);
    send_block('1, '1);

    // standard key, encrypt
    write_reg(sm4_pkg::CFG_KEY_HIGH, STD_KEY_HI);
    write_reg(sm4_pkg::CFG_KEY_LOW, STD_KEY_LO);
    send_block(STD_KEY_HI, STD_KEY_LO);
    send_block(64'h8000000000000000, 64'h0);
    send_block(64'h0, 64'h1);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);

    // wide mode value, bit 0 set: decrypt
    write_reg(sm4_pkg::CFG_MODE, '1);
    send_block(STD_CT_HI, STD_CT_LO);
    send_block('0, '0);

    // spare index leaves key and mode alone
    write_reg(CFG_SPARE, '1);
    send_block(STD_CT_HI, STD_CT_LO);

    // wide mode value, bit 0 clear: encrypt
    write_reg(sm4_pkg::CFG_MODE, 64'hfffffffffffffffe);
    send_block('1, '1);

    // all-ones key both ways
    write_reg(sm4_pkg::CFG_KEY_HIGH, '1);
    write_reg(sm4_pkg::CFG_KEY_LOW, '1);
    send_block('0, '0);
    send_block('1, '1);
    write_reg(sm4_pkg::CFG_MODE, MODE_DEC);
    send_block('0, '1);

    // back to zero key, encrypt
    write_reg(sm4_pkg::CFG_KEY_HIGH, '0);
    write_reg(sm4_pkg::CFG_KEY_LOW, '0);
    write_reg(sm4_pkg::CFG_MODE, MODE_ENC);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);

    // random phases: a few register writes, then a run of items
    while (items_sent < ITEM_TARGET) begin
      repeat ($urandom_range(1, 3)) write_reg(2'($urandom_range(0, 3)), rand_word());
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(4, 40);
      repeat (phase_len) begin
        if (items_sent < ITEM_TARGET) begin
          if (gaps_on && items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 2) == 0)
            sender_gap();
          send_block(rand_word(), rand_word());
        end
      end
    end
    start = 1'b0;

    // drain
    do @(posedge clk); while (blocks_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sm4_pkg.sv
rtl/core/sm4_rk_mem.sv
rtl/core/sm4_round.sv
rtl/core/sm4_ctrl.sv
rtl/core/sm4_block_cipher.sv
rtl/core/sm4_chk.sv
tb/sv/sm4_checker.sv
tb/sv/tb_top.sv
